FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the flight log field decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is low.
`define FLD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define FLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/fld_pkg.sv
// ----------------------------------------------------------------------------
// Flight log field decoder package
// Encoding codes, result bundle types and sign extension helpers.
// ----------------------------------------------------------------------------
package fld_pkg;

    // Group encodings, latched from the opcode on the first byte of a group
    typedef enum logic [2:0] {
        OP_UVAR   = 3'd0,
        OP_ZIGZAG = 3'd1,
        OP_TAG2   = 3'd2,
        OP_TAG8   = 3'd3,
        OP_RAW    = 3'd4
    } opcode_t;

    // Tag2 layouts, top two bits of the lead byte
    typedef enum logic [1:0] {
        T2_CRUMBS  = 2'd0,
        T2_NIBBLES = 2'd1,
        T2_SIXES   = 2'd2,
        T2_BYTES   = 2'd3
    } t2_layout_t;

    // Tag8 field sizes, two selector bits per value
    typedef enum logic [1:0] {
        T8_ZERO = 2'd0,
        T8_NIB  = 2'd1,
        T8_BYTE = 2'd2,
        T8_WORD = 2'd3
    } t8_field_t;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned VARINT_MAX_BYTES = 5;

    typedef struct packed {
        logic [31:0] value;
        logic        group_last;
        logic        overlong;
    } result_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [2:0]                     count;
        result_t [MAX_RESULTS-1:0]      res;
    } bundle_t;

    function automatic logic [31:0] sext2(input logic [1:0] v);
        return {{30{v[1]}}, v};
    endfunction

    function automatic logic [31:0] sext4(input logic [3:0] v);
        return {{28{v[3]}}, v};
    endfunction

    function automatic logic [31:0] sext6(input logic [5:0] v);
        return {{26{v[5]}}, v};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sext24(input logic [23:0] v);
        return {{8{v[23]}}, v};
    endfunction

    function automatic result_t res_of(input logic [31:0] v, input logic last,
                                       input logic ovl);
        result_t r;
        r.value      = v;
        r.group_last = last;
        r.overlong   = ovl;
        return r;
    endfunction

endpackage

FILE: rtl/fld_stream_if.sv
// ----------------------------------------------------------------------------
// Flight log decoder stream interfaces
// Valid/ready channels for log bytes in and decoded field values out.
// ----------------------------------------------------------------------------

// Log byte channel
interface fld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] opcode;
    logic       sign_extend;

    modport source (output valid, data_byte, opcode, sign_extend, input ready);
    modport sink   (input valid, data_byte, opcode, sign_extend, output ready);
endinterface

// Decoded value channel
interface fld_value_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               group_last;
    logic               overlong;

    modport source (output valid, value, group_last, overlong, input ready);
    modport sink   (input valid, value, group_last, overlong, output ready);
endinterface

FILE: rtl/fld_decode_core.sv
// ----------------------------------------------------------------------------
// Flight log decode core
// Input register, group state and the per-byte decode step that produces
// a bundle of up to four results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fld_decode_core
(
    input  logic             clk,
    input  logic             rst_n,
    fld_byte_if.sink         log_bytes,
    output fld_pkg::bundle_t bundle,
    output logic             bundle_valid,
    input  logic             bundle_ready
);

    // Input register
    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic [2:0] opcode_reg;
    logic       sext_reg;

    // Group state
    logic               busy_reg,  busy_next;
    fld_pkg::opcode_t   mode_reg,  mode_next;
    logic [31:0]        acc_reg,   acc_next;
    logic [2:0]         bcnt_reg,  bcnt_next;
    logic [7:0]         tsel_reg,  tsel_next;
    logic [1:0]         vidx_reg,  vidx_next;
    logic [7:0]         nbuf_reg,  nbuf_next;
    logic               npend_reg, npend_next;

    // Decode step working values
    fld_pkg::bundle_t     step;
    logic                 first;
    logic                 have;
    logic                 stop;
    logic                 emit_now;
    logic [31:0]          vint;
    logic [31:0]          v;
    logic                 last;
    logic [1:0]           size_code;
    fld_pkg::t2_layout_t  layout;
    fld_pkg::t8_field_t   fcode;

    logic adv;
    logic in_fire;
    logic final_last;

    assign in_fire         = log_bytes.valid && log_bytes.ready;
    assign adv             = in_vld_reg && bundle_ready;
    assign log_bytes.ready = !in_vld_reg || bundle_ready;
    assign bundle_valid    = in_vld_reg;
    assign bundle          = step;

    // Per-byte decode step
    always_comb
    begin
        busy_next  = busy_reg;
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        bcnt_next  = bcnt_reg;
        tsel_next  = tsel_reg;
        vidx_next  = vidx_reg;
        nbuf_next  = nbuf_reg;
        npend_next = npend_reg;
        step       = '0;
        first      = 1'b0;
        have       = 1'b0;
        stop       = 1'b0;
        emit_now   = 1'b0;
        vint       = '0;
        v          = '0;
        last       = 1'b0;
        size_code  = '0;
        layout     = fld_pkg::T2_CRUMBS;
        fcode      = fld_pkg::T8_ZERO;

        // Group start; unknown encodings drop the byte
        if (!busy_reg)
        begin
            if (opcode_reg <= 3'(fld_pkg::OP_RAW))
            begin
                mode_next  = fld_pkg::opcode_t'(opcode_reg);
                busy_next  = 1'b1;
                acc_next   = '0;
                bcnt_next  = '0;
                vidx_next  = '0;
                nbuf_next  = '0;
                npend_next = 1'b0;
                first      = 1'b1;
            end
        end

        if (busy_next)
        begin
            case (mode_next)
                fld_pkg::OP_UVAR, fld_pkg::OP_ZIGZAG:
                begin
                    // 7 payload bits per byte, low group first
                    case (bcnt_next)
                        3'd0:    acc_next = acc_next | {25'd0, byte_reg[6:0]};
                        3'd1:    acc_next = acc_next | {18'd0, byte_reg[6:0], 7'd0};
                        3'd2:    acc_next = acc_next | {11'd0, byte_reg[6:0], 14'd0};
                        3'd3:    acc_next = acc_next | {4'd0, byte_reg[6:0], 21'd0};
                        3'd4:    acc_next = acc_next | {byte_reg[3:0], 28'd0};
                        default: acc_next = acc_next;
                    endcase
                    if (!byte_reg[7])
                    begin
                        vint = acc_next;
                        if (mode_next == fld_pkg::OP_ZIGZAG)
                        begin
                            vint = {1'b0, vint[31:1]} ^ {32{vint[0]}};
                        end
                        step.res[0] = fld_pkg::res_of(vint, 1'b1, 1'b0);
                        step.count  = 3'd1;
                        busy_next   = 1'b0;
                    end
                    else
                    begin
                        bcnt_next = bcnt_next + 3'd1;
                        // continuation on the last allowed byte: overlong
                        if (bcnt_next >= 3'(fld_pkg::VARINT_MAX_BYTES))
                        begin
                            step.res[0] = fld_pkg::res_of('0, 1'b1, 1'b1);
                            step.count  = 3'd1;
                            busy_next   = 1'b0;
                        end
                    end
                end

                fld_pkg::OP_TAG2:
                begin
                    if (first)
                    begin
                        tsel_next = byte_reg;
                        layout    = fld_pkg::t2_layout_t'(byte_reg[7:6]);
                        case (layout)
                            fld_pkg::T2_CRUMBS:
                            begin
                                step.res[0] = fld_pkg::res_of(
                                    fld_pkg::sext2(byte_reg[5:4]), 1'b0, 1'b0);
                                step.res[1] = fld_pkg::res_of(
                                    fld_pkg::sext2(byte_reg[3:2]), 1'b0, 1'b0);
                                step.res[2] = fld_pkg::res_of(
                                    fld_pkg::sext2(byte_reg[1:0]), 1'b1, 1'b0);
                                step.count  = 3'd3;
                                busy_next   = 1'b0;
                            end
                            fld_pkg::T2_NIBBLES:
                            begin
                                step.res[0] = fld_pkg::res_of(
                                    fld_pkg::sext4(byte_reg[3:0]), 1'b0, 1'b0);
                                step.count  = 3'd1;
                                vidx_next   = 2'd1;
                            end
                            fld_pkg::T2_SIXES:
                            begin
                                step.res[0] = fld_pkg::res_of(
                                    fld_pkg::sext6(byte_reg[5:0]), 1'b0, 1'b0);
                                step.count  = 3'd1;
                                vidx_next   = 2'd1;
                            end
                            default:
                            begin
                                // byte-size layout: lead byte only holds sizes
                            end
                        endcase
                    end
                    else
                    begin
                        layout = fld_pkg::t2_layout_t'(tsel_reg[7:6]);
                        case (layout)
                            fld_pkg::T2_NIBBLES:
                            begin
                                step.res[0] = fld_pkg::res_of(
                                    fld_pkg::sext4(byte_reg[7:4]), 1'b0, 1'b0);
                                step.res[1] = fld_pkg::res_of(
                                    fld_pkg::sext4(byte_reg[3:0]), 1'b1, 1'b0);
                                step.count  = 3'd2;
                                busy_next   = 1'b0;
                            end
                            fld_pkg::T2_SIXES:
                            begin
                                last        = (vidx_next >= 2'd2);
                                step.res[0] = fld_pkg::res_of(
                                    fld_pkg::sext6(byte_reg[5:0]), last, 1'b0);
                                step.count  = 3'd1;
                                if (last)
                                    busy_next = 1'b0;
                                else
                                    vidx_next = vidx_next + 2'd1;
                            end
                            fld_pkg::T2_BYTES:
                            begin
                                // little-endian bytes, 1 to 4 per value
                                size_code = tsel_reg[{vidx_next, 1'b0} +: 2];
                                if (!bcnt_next[2])
                                begin
                                    acc_next[{bcnt_next[1:0], 3'b000} +: 8] =
                                        acc_next[{bcnt_next[1:0], 3'b000} +: 8] | byte_reg;
                                end
                                bcnt_next = bcnt_next + 3'd1;
                                if (bcnt_next >= ({1'b0, size_code} + 3'd1))
                                begin
                                    case (size_code)
                                        2'd0:    v = fld_pkg::sext8(acc_next[7:0]);
                                        2'd1:    v = fld_pkg::sext16(acc_next[15:0]);
                                        2'd2:    v = fld_pkg::sext24(acc_next[23:0]);
                                        default: v = acc_next;
                                    endcase
                                    last        = (vidx_next >= 2'd2);
                                    step.res[0] = fld_pkg::res_of(v, last, 1'b0);
                                    step.count  = 3'd1;
                                    acc_next    = '0;
                                    bcnt_next   = '0;
                                    if (last)
                                        busy_next = 1'b0;
                                    else
                                        vidx_next = vidx_next + 2'd1;
                                end
                            end
                            default:
                            begin
                                busy_next = 1'b0;
                            end
                        endcase
                    end
                end

                fld_pkg::OP_TAG8:
                begin
                    if (first)
                        tsel_next = byte_reg;
                    have = !first;
                    // One slot per value; each slot emits or stops the walk
                    for (int k = 0; k < 4; k++)
                    begin
                        if (busy_next && !stop)
                        begin
                            fcode    = fld_pkg::t8_field_t'(tsel_next[{vidx_next, 1'b0} +: 2]);
                            emit_now = 1'b1;
                            v        = '0;
                            case (fcode)
                                fld_pkg::T8_ZERO:
                                begin
                                    v = '0;
                                end
                                fld_pkg::T8_NIB:
                                begin
                                    if (npend_next)
                                    begin
                                        v          = fld_pkg::sext4(nbuf_next[3:0]);
                                        npend_next = 1'b0;
                                    end
                                    else if (have)
                                    begin
                                        have       = 1'b0;
                                        nbuf_next  = byte_reg;
                                        v          = fld_pkg::sext4(byte_reg[7:4]);
                                        npend_next = 1'b1;
                                    end
                                    else
                                    begin
                                        emit_now = 1'b0;
                                        stop     = 1'b1;
                                    end
                                end
                                fld_pkg::T8_BYTE:
                                begin
                                    if (!have)
                                    begin
                                        emit_now = 1'b0;
                                        stop     = 1'b1;
                                    end
                                    else
                                    begin
                                        have = 1'b0;
                                        if (!npend_next)
                                        begin
                                            v = fld_pkg::sext8(byte_reg);
                                        end
                                        else
                                        begin
                                            v = fld_pkg::sext8({nbuf_next[3:0], byte_reg[7:4]});
                                            nbuf_next = byte_reg;
                                        end
                                    end
                                end
                                default:
                                begin
                                    // 16-bit big-endian field over two bytes
                                    if (!have)
                                    begin
                                        emit_now = 1'b0;
                                        stop     = 1'b1;
                                    end
                                    else
                                    begin
                                        have = 1'b0;
                                        if (bcnt_next == 3'd0)
                                        begin
                                            acc_next  = {24'd0, byte_reg};
                                            bcnt_next = 3'd1;
                                            emit_now  = 1'b0;
                                            stop      = 1'b1;
                                        end
                                        else
                                        begin
                                            if (!npend_next)
                                            begin
                                                v = fld_pkg::sext16({acc_next[7:0], byte_reg});
                                            end
                                            else
                                            begin
                                                v = fld_pkg::sext16({nbuf_next[3:0],
                                                    acc_next[7:0], byte_reg[7:4]});
                                                nbuf_next = byte_reg;
                                            end
                                            acc_next  = '0;
                                            bcnt_next = '0;
                                        end
                                    end
                                end
                            endcase
                            if (emit_now)
                            begin
                                last        = (vidx_next == 2'd3);
                                step.res[k] = fld_pkg::res_of(v, last, 1'b0);
                                step.count  = 3'(k + 1);
                                if (last)
                                    busy_next = 1'b0;
                                else
                                    vidx_next = vidx_next + 2'd1;
                            end
                        end
                    end
                end

                fld_pkg::OP_RAW:
                begin
                    v = sext_reg ? fld_pkg::sext8(byte_reg) : {24'd0, byte_reg};
                    step.res[0] = fld_pkg::res_of(v, 1'b1, 1'b0);
                    step.count  = 3'd1;
                    busy_next   = 1'b0;
                end

                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg   <= log_bytes.data_byte;
            opcode_reg <= log_bytes.opcode;
            sext_reg   <= log_bytes.sign_extend;
        end
    end

    // Group state, updated as each byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            mode_reg  <= fld_pkg::OP_UVAR;
            acc_reg   <= '0;
            bcnt_reg  <= '0;
            tsel_reg  <= '0;
            vidx_reg  <= '0;
            nbuf_reg  <= '0;
            npend_reg <= 1'b0;
        end
        else if (adv)
        begin
            busy_reg  <= busy_next;
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            bcnt_reg  <= bcnt_next;
            tsel_reg  <= tsel_next;
            vidx_reg  <= vidx_next;
            nbuf_reg  <= nbuf_next;
            npend_reg <= npend_next;
        end
    end

    assign final_last = step.res[2'(step.count - 3'd1)].group_last;

    // Closing an open group always yields at least one result
    `FLD_ASSERT(a_close_emits, clk, rst_n, (adv && busy_reg && !busy_next) |-> (step.count != 3'd0))
    // The final result of a byte that closes a group carries the group mark
    `FLD_ASSERT(a_close_marks_last, clk, rst_n, (adv && !busy_next && step.count != 3'd0) |-> final_last)

endmodule

FILE: rtl/fld_result_buf.sv
// ----------------------------------------------------------------------------
// Flight log result buffer
// Holds one bundle of results, handing them out one per ready cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fld_result_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  fld_pkg::bundle_t bundle,
    input  logic             bundle_valid,
    output logic             bundle_ready,
    fld_value_if.source      field_values
);

    fld_pkg::result_t [fld_pkg::MAX_RESULTS-1:0] slots_reg;
    logic [2:0] rem_reg, rem_next;
    logic [1:0] idx_reg, idx_next;

    logic load;
    logic fire;

    assign fire = field_values.valid && field_values.ready;
    assign load = bundle_valid && bundle_ready;

    // Take a new bundle when empty or while its last result is being taken
    assign bundle_ready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && field_values.ready);

    // Read pointer and remaining count
    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = bundle.count;
            idx_next = '0;
        end
        else if (fire)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg <= bundle.res;
        end
    end

    // Output port
    assign field_values.valid      = (rem_reg != 3'd0);
    assign field_values.value      = slots_reg[idx_reg].value;
    assign field_values.group_last = slots_reg[idx_reg].group_last;
    assign field_values.overlong   = slots_reg[idx_reg].overlong;

    `FLD_ASSERT(a_rem_bound, clk, rst_n, rem_reg <= 3'(fld_pkg::MAX_RESULTS))
    `FLD_ASSERT_NEXT(a_rem_drain, clk, rst_n, fire && !load, rem_reg == $past(rem_reg) - 3'd1)
    `FLD_ASSERT(a_overlong_zero, clk, rst_n, (field_values.valid && field_values.overlong) |-> (field_values.group_last && field_values.value == 32'sd0))

endmodule

FILE: rtl/flight_log_field_decoder.sv
// ----------------------------------------------------------------------------
// Flight log field decoder
// Decodes varint, zigzag, tag2, tag8 and raw byte fields from a log byte
// stream into 32-bit values with a last-of-group mark.
// ----------------------------------------------------------------------------
// Path: a taken byte is held in the input register, decoded, then loaded into
// the result buffer, whose slots present its first result.
// Throughput: one byte per cycle while the output is ready and each byte
// yields at most one result; a byte yielding more than one result holds the
// input while the single result port drains them, one value per ready cycle.
// Reset: clears the input register, result buffer and group state; idle at once.

module flight_log_field_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    fld_byte_if.sink    log_bytes,
    fld_value_if.source field_values
);

    fld_pkg::bundle_t bundle;
    logic             bundle_valid;
    logic             bundle_ready;

    // Input register, group state and decode step
    fld_decode_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .log_bytes    (log_bytes),
        .bundle       (bundle),
        .bundle_valid (bundle_valid),
        .bundle_ready (bundle_ready)
    );

    // Result register and serializer
    fld_result_buf u_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle       (bundle),
        .bundle_valid (bundle_valid),
        .bundle_ready (bundle_ready),
        .field_values (field_values)
    );

endmodule

FILE: sim/flight_log_field_decoder_test.sv
// ----------------------------------------------------------------------------
// Flight log field decoder testbench
// Feeds directed and random byte groups of every encoding through the byte
// channel, with random gaps and output stalls, and checks each decoded value
// against planned values or against an in-bench decoder of the same stream.
// ----------------------------------------------------------------------------

module flight_log_field_decoder_test;

    import fld_pkg::*;

    // Opcodes with no encoding; a group start with one of these is dropped
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int QUIET_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]  b;
        logic [2:0]  op;
        logic        sx;
        logic        typed;   // expected values given in the row
        logic [2:0]  n;       // number of values when typed
        logic [31:0] val;     // every typed value of the row
        logic        ovl;     // overlong mark on the last typed value
    } plan_row_t;

    logic clk;
    logic rst_n;

    fld_byte_if  bytes_ch ();
    fld_value_if values_ch ();

    flight_log_field_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .log_bytes    (bytes_ch),
        .field_values (values_ch)
    );

    // In-bench decoder state
    logic        grp_open;
    opcode_t     grp_mode;
    logic [31:0] acc;
    logic [2:0]  nbytes;
    logic [7:0]  sel;
    logic [1:0]  vidx;
    logic [7:0]  nib_buf;
    logic        nib_pend;
    logic        byte_dropped;

    result_t     fresh_q[$];
    result_t     pending_values[$];
    plan_row_t   plan_q[$];

    int          items_fed;
    int          values_checked;
    int          overlong_seen;
    int          mismatches;
    int          quiet_cycles;
    int          stall_left;
    int          groups_seen[0:4];
    logic        calm;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic [31:0] widen(input logic [31:0] v, input int bits);
        logic [31:0] mask;
        if (bits >= 32 || bits == 0)
            return v;
        mask = (32'd1 << bits) - 32'd1;
        v = v & mask;
        if (v[bits-1])
            v = v | ~mask;
        return v;
    endfunction

    function automatic result_t mk(input logic [31:0] v, input logic last,
                                   input logic ovl);
        result_t r;
        r.value      = v;
        r.group_last = last;
        r.overlong   = ovl;
        return r;
    endfunction

    task automatic put(input logic [31:0] v, input logic last, input logic ovl);
        if (fresh_q.size() < MAX_RESULTS)
            fresh_q.push_back(mk(v, last, ovl));
    endtask

    // Decode one accepted byte; values it completes land in fresh_q
    task automatic decode_byte(input logic [7:0] b, input logic [2:0] op,
                               input logic sx);
        logic        first;
        logic        have;
        logic        fire;
        logic        last;
        logic [31:0] v;
        logic [7:0]  c1;
        int          size;
        fresh_q.delete();
        byte_dropped = 1'b0;
        first = 1'b0;
        if (!grp_open)
        begin
            if (op > OP_RAW)
            begin
                byte_dropped = 1'b1;
                return;
            end
            grp_mode = opcode_t'(op);
            grp_open = 1'b1;
            acc      = '0;
            nbytes   = '0;
            vidx     = '0;
            nib_buf  = '0;
            nib_pend = 1'b0;
            first    = 1'b1;
            groups_seen[op]++;
        end
        case (grp_mode)
            OP_UVAR, OP_ZIGZAG:
            begin
                if (nbytes < VARINT_MAX_BYTES)
                    acc = acc | ({25'd0, b[6:0]} << (7 * nbytes));
                if (!b[7])
                begin
                    v = acc;
                    if (grp_mode == OP_ZIGZAG)
                        v = (v >> 1) ^ (32'd0 - {31'd0, v[0]});
                    put(v, 1'b1, 1'b0);
                    grp_open = 1'b0;
                end
                else
                begin
                    nbytes = nbytes + 3'd1;
                    if (nbytes >= VARINT_MAX_BYTES)
                    begin
                        put(32'd0, 1'b1, 1'b1);
                        grp_open = 1'b0;
                    end
                end
            end
            OP_TAG2:
            begin
                if (first)
                begin
                    sel = b;
                    case (t2_layout_t'(b[7:6]))
                        T2_CRUMBS:
                        begin
                            put(widen({30'd0, b[5:4]}, 2), 1'b0, 1'b0);
                            put(widen({30'd0, b[3:2]}, 2), 1'b0, 1'b0);
                            put(widen({30'd0, b[1:0]}, 2), 1'b1, 1'b0);
                            grp_open = 1'b0;
                        end
                        T2_NIBBLES:
                        begin
                            put(widen({28'd0, b[3:0]}, 4), 1'b0, 1'b0);
                            vidx = 2'd1;
                        end
                        T2_SIXES:
                        begin
                            put(widen({26'd0, b[5:0]}, 6), 1'b0, 1'b0);
                            vidx = 2'd1;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    case (t2_layout_t'(sel[7:6]))
                        T2_NIBBLES:
                        begin
                            put(widen({28'd0, b[7:4]}, 4), 1'b0, 1'b0);
                            put(widen({28'd0, b[3:0]}, 4), 1'b1, 1'b0);
                            grp_open = 1'b0;
                        end
                        T2_SIXES:
                        begin
                            last = (vidx >= 2'd2);
                            put(widen({26'd0, b[5:0]}, 6), last, 1'b0);
                            if (last)
                                grp_open = 1'b0;
                            else
                                vidx = vidx + 2'd1;
                        end
                        T2_BYTES:
                        begin
                            // byte count per value from the lead byte
                            size = int'(sel[2*vidx +: 2]) + 1;
                            if (nbytes < 4)
                                acc = acc | ({24'd0, b} << (8 * nbytes));
                            nbytes = nbytes + 3'd1;
                            if (nbytes >= size)
                            begin
                                last = (vidx >= 2'd2);
                                put(widen(acc, 8 * size), last, 1'b0);
                                acc    = '0;
                                nbytes = '0;
                                if (last)
                                    grp_open = 1'b0;
                                else
                                    vidx = vidx + 2'd1;
                            end
                        end
                        default:
                            grp_open = 1'b0;
                    endcase
                end
            end
            OP_TAG8:
            begin
                if (first)
                    sel = b;
                have = !first;
                fire = 1'b1;
                // emit every field that is complete without another byte
                while (grp_open && fire)
                begin
                    v = '0;
                    case (t8_field_t'(sel[2*vidx +: 2]))
                        T8_ZERO:
                            v = '0;
                        T8_NIB:
                        begin
                            if (nib_pend)
                            begin
                                v = widen({28'd0, nib_buf[3:0]}, 4);
                                nib_pend = 1'b0;
                            end
                            else if (have)
                            begin
                                have = 1'b0;
                                nib_buf = b;
                                v = widen({28'd0, b[7:4]}, 4);
                                nib_pend = 1'b1;
                            end
                            else
                                fire = 1'b0;
                        end
                        T8_BYTE:
                        begin
                            if (!have)
                                fire = 1'b0;
                            else
                            begin
                                have = 1'b0;
                                if (!nib_pend)
                                    v = widen({24'd0, b}, 8);
                                else
                                begin
                                    v = widen({24'd0, nib_buf[3:0], b[7:4]}, 8);
                                    nib_buf = b;
                                end
                            end
                        end
                        default:
                        begin
                            // 16-bit big-endian field, first byte held in acc
                            if (!have)
                                fire = 1'b0;
                            else
                            begin
                                have = 1'b0;
                                if (nbytes == 3'd0)
                                begin
                                    acc = {24'd0, b};
                                    nbytes = 3'd1;
                                    fire = 1'b0;
                                end
                                else
                                begin
                                    c1 = acc[7:0];
                                    if (!nib_pend)
                                        v = {16'd0, c1, b};
                                    else
                                    begin
                                        v = {16'd0, nib_buf[3:0], c1, b[7:4]};
                                        nib_buf = b;
                                    end
                                    v = widen(v, 16);
                                    acc = '0;
                                    nbytes = '0;
                                end
                            end
                        end
                    endcase
                    if (fire)
                    begin
                        last = (vidx == 2'd3);
                        put(v, last, 1'b0);
                        if (last)
                            grp_open = 1'b0;
                        else
                            vidx = vidx + 2'd1;
                    end
                end
            end
            OP_RAW:
            begin
                put(sx ? widen({24'd0, b}, 8) : {24'd0, b}, 1'b1, 1'b0);
                grp_open = 1'b0;
            end
            default:
                grp_open = 1'b0;
        endcase
    endtask

    // Present one request, wait for it to be taken, record what it should yield
    task automatic offer_byte(input plan_row_t row);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(10, 1);
            bytes_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        bytes_ch.valid       = 1'b1;
        bytes_ch.data_byte   = row.b;
        bytes_ch.opcode      = row.op;
        bytes_ch.sign_extend = row.sx;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        decode_byte(row.b, row.op, row.sx);
        if (!byte_dropped)
            items_fed++;
        if (row.typed)
        begin
            for (int k = 0; k < int'(row.n); k++)
                pending_values.push_back(mk(row.val, k == int'(row.n) - 1,
                                            row.ovl && (k == int'(row.n) - 1)));
        end
        else
        begin
            foreach (fresh_q[k])
                pending_values.push_back(fresh_q[k]);
        end
    endtask

    task automatic plan(input logic [7:0] b, input logic [2:0] op, input logic sx,
                        input logic typed, input logic [2:0] n,
                        input logic [31:0] val, input logic ovl);
        plan_row_t row;
        row.b     = b;
        row.op    = op;
        row.sx    = sx;
        row.typed = typed;
        row.n     = n;
        row.val   = val;
        row.ovl   = ovl;
        plan_q.push_back(row);
    endtask

    task automatic feed(input logic [7:0] b, input logic [2:0] op, input logic sx);
        plan_row_t row;
        row       = '0;
        row.b     = b;
        row.op    = op;
        row.sx    = sx;
        offer_byte(row);
    endtask

    // Result side: random stall bursts, steady in the last part of the run
    always @(negedge clk)
    begin
        if (calm)
            values_ch.ready = 1'b1;
        else if (stall_left > 0)
        begin
            values_ch.ready = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(4) == 0)
        begin
            values_ch.ready = 1'b0;
            stall_left = $urandom_range(10, 1) - 1;
        end
        else
            values_ch.ready = 1'b1;
    end

    // Compare each taken value with the oldest expectation
    always @(posedge clk)
    begin : check_value
        result_t want;
        if (rst_n && values_ch.valid && values_ch.ready)
        begin
            if (pending_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected value %h last %0b overlong %0b",
                             values_ch.value, values_ch.group_last,
                             values_ch.overlong);
            end
            else
            begin
                want = pending_values.pop_front();
                values_checked++;
                if (want.overlong)
                    overlong_seen++;
                if (want.value !== values_ch.value
                    || want.group_last !== values_ch.group_last
                    || want.overlong !== values_ch.overlong)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("value mismatch: expected %h/%0b/%0b got %h/%0b/%0b",
                                 want.value, want.group_last, want.overlong,
                                 values_ch.value, values_ch.group_last,
                                 values_ch.overlong);
                end
            end
        end
    end

    // Watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if ((bytes_ch.valid && bytes_ch.ready) || (values_ch.valid && values_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0] rb;
        int         pick;
        int         len;
        rst_n                = 1'b0;
        bytes_ch.valid       = 1'b0;
        bytes_ch.data_byte   = '0;
        bytes_ch.opcode      = '0;
        bytes_ch.sign_extend = 1'b0;
        values_ch.ready      = 1'b0;
        grp_open             = 1'b0;
        grp_mode             = OP_UVAR;
        acc                  = '0;
        nbytes               = '0;
        sel                  = '0;
        vidx                 = '0;
        nib_buf              = '0;
        nib_pend             = 1'b0;
        byte_dropped         = 1'b0;
        items_fed            = 0;
        values_checked       = 0;
        overlong_seen        = 0;
        mismatches           = 0;
        quiet_cycles         = 0;
        stall_left           = 0;
        calm                 = 1'b0;
        foreach (groups_seen[k])
            groups_seen[k] = 0;

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: raw extremes, dropped opcodes, varint limits, tags
        plan(8'hFF, OP_RAW, 1'b1, 1'b1, 3'd1, 32'hFFFF_FFFF, 1'b0);
        plan(8'hFF, OP_RAW, 1'b0, 1'b1, 3'd1, 32'h0000_00FF, 1'b0);
        plan(8'h80, OP_RAW, 1'b1, 1'b1, 3'd1, 32'hFFFF_FF80, 1'b0);
        plan(8'h12, OP_UNUSED_LO, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'hFF, OP_UNUSED_HI, 1'b1, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'h7F, OP_UVAR, 1'b0, 1'b1, 3'd1, 32'h0000_007F, 1'b0);
        // largest five-byte varint; opcodes on later bytes are ignored
        plan(8'hFF, OP_UVAR, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'hFF, OP_TAG8, 1'b1, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'hFF, OP_UNUSED_HI, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'hFF, OP_RAW, 1'b1, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'h0F, OP_TAG2, 1'b0, 1'b1, 3'd1, 32'hFFFF_FFFF, 1'b0);
        // overlong zigzag varint forced to zero
        plan(8'h80, OP_ZIGZAG, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'h80, OP_ZIGZAG, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'h80, OP_ZIGZAG, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'h80, OP_ZIGZAG, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
        plan(8'h80, OP_ZIGZAG, 1'b0, 1'b1, 3'd1, 32'd0, 1'b1);
        plan(8'h01, OP_ZIGZAG, 1'b0, 1'b1, 3'd1, 32'hFFFF_FFFF, 1'b0);
        // all-zero tag8 selector: four values from one byte
        plan(8'h00, OP_TAG8, 1'b0, 1'b1, 3'd4, 32'd0, 1'b0);
        plan(8'h2A, OP_TAG2, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        plan(8'h4F, OP_TAG2, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        plan(8'h7F, OP_UVAR, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        // tag8 with zero, nibble, byte and word fields off nibble boundaries
        plan(8'hE4, OP_TAG8, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        plan(8'hA5, OP_TAG8, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        plan(8'h3C, OP_TAG8, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        plan(8'h80, OP_TAG8, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        plan(8'h01, OP_TAG8, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
        foreach (plan_q[k])
            offer_byte(plan_q[k]);

        // Random groups; continuation bytes carry random opcodes
        while (items_fed < plan_q.size() + RANDOM_ITEMS)
        begin
            if (items_fed >= plan_q.size() + RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(99);
            if (pick < 8)
                feed(8'($urandom), 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                     1'($urandom_range(1)));
            else if (pick < 44)
            begin
                len = ($urandom_range(9) == 0) ? VARINT_MAX_BYTES
                                               : $urandom_range(VARINT_MAX_BYTES, 1);
                for (int k = 0; k < len; k++)
                begin
                    rb = 8'($urandom);
                    rb[7] = (k < len - 1) || (len == VARINT_MAX_BYTES && rb[0]);
                    feed(rb, (k == 0) ? ((pick < 26) ? OP_UVAR : OP_ZIGZAG)
                                      : 3'($urandom_range(7)),
                         1'($urandom_range(1)));
                end
            end
            else if (pick < 84)
            begin
                feed(8'($urandom), (pick < 64) ? OP_TAG2 : OP_TAG8,
                     1'($urandom_range(1)));
                while (grp_open)
                    feed(8'($urandom), 3'($urandom_range(7)), 1'($urandom_range(1)));
            end
            else
                feed(8'($urandom), OP_RAW, 1'($urandom_range(1)));
        end

        @(negedge clk);
        bytes_ch.valid = 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d bytes: %0d uvar, %0d zigzag, %0d tag2, %0d tag8, %0d raw groups",
                 items_fed, groups_seen[OP_UVAR], groups_seen[OP_ZIGZAG],
                 groups_seen[OP_TAG2], groups_seen[OP_TAG8], groups_seen[OP_RAW]);
        $display("Compared %0d values (%0d overlong), %0d mismatches",
                 values_checked, overlong_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
